FILE: hw/rtl/mspf_pkg.sv
// ----------------------------------------------------------------------------
// mspf_pkg
// Types, command codes and register indexes of the motor serial packet framer.
// ----------------------------------------------------------------------------
package mspf_pkg;

    // Command bytes of the motor driver protocol.
    localparam logic [7:0] OP_FORWARD = 8'd8;
    localparam logic [7:0] OP_REVERSE = 8'd9;
    localparam logic [7:0] OP_RIGHT   = 8'd10;
    localparam logic [7:0] OP_LEFT    = 8'd11;
    localparam logic [7:0] OP_TIMEOUT = 8'd14;

    localparam logic [7:0] CHECK_MASK = 8'h7F;

    // Item kinds.
    localparam logic ITEM_DRIVE   = 1'b0;
    localparam logic ITEM_TIMEOUT = 1'b1;

    // Target selection for drive items.
    localparam logic TARGET_PROPULSION = 1'b0;

    // Configuration register indexes.
    localparam logic [1:0] REG_PROPULSION_ADDR = 2'd0;
    localparam logic [1:0] REG_CONVEYOR_ADDR   = 2'd1;
    localparam logic [1:0] REG_DEADBAND        = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_VALUE   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_PROPULSION_ADDR = 8'd128;
    localparam logic [7:0]  RST_CONVEYOR_ADDR   = 8'd132;
    localparam logic [14:0] RST_DEADBAND        = 15'd164;
    localparam logic [6:0]  RST_TIMEOUT_VALUE   = 7'd10;

    // Byte slots of the serial checksum in an eight-byte item.
    localparam logic [2:0] SLOT_FIRST_CHECK = 3'd3;
    localparam logic [2:0] SLOT_LAST        = 3'd7;

    // One shaped drive value.
    typedef struct packed {
        logic       above;
        logic       below;
        logic [6:0] value;
    } shape_t;

    // Eight serial bytes; byte 0 goes out first.
    typedef logic [7:0][7:0] item_bytes_t;
    typedef logic [3:0][7:0] packet_t;

    function automatic packet_t make_packet(
        input logic [7:0] addr,
        input logic [7:0] op,
        input logic [7:0] val
    );
        packet_t    p;
        logic [7:0] sum;
        sum  = addr + op + val;
        p[0] = addr;
        p[1] = op;
        p[2] = val;
        p[3] = sum & CHECK_MASK;
        return p;
    endfunction

endpackage

FILE: hw/rtl/motor_serial_packet_framer.sv
// ----------------------------------------------------------------------------
// motor_serial_packet_framer
// Turns drive and timeout items into two four-byte driver packets each.
// An accepted item is registered in the item stage, then in the byte stage, which drives its first byte.
// The output port gives one byte per cycle while out_stall is low.
// The item stage refills while the byte stage still sends the previous item.
// Reset clears both stages and loads the register defaults.
// ----------------------------------------------------------------------------
module motor_serial_packet_framer #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic        target,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] turn_rate,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        last
);

    // Signed working width: holds the clamped value and minus the deadband.
    localparam int VW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam logic signed [VW-1:0] ONE_Q = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [7:0]  prop_addr_reg;
    logic [7:0]  conv_addr_reg;
    logic [14:0] deadband_reg;
    logic [6:0]  timeout_reg;

    logic                 a_valid_reg, a_valid_next;
    mspf_pkg::item_bytes_t a_bytes_reg;
    logic                 b_valid_reg, b_valid_next;
    mspf_pkg::item_bytes_t b_bytes_reg;
    logic [2:0]           b_cnt_reg, b_cnt_next;

    logic in_fire, out_fire, b_done, b_load;
    logic [7:0] drive_addr;
    mspf_pkg::shape_t speed_s, turn_s;
    mspf_pkg::packet_t pkt0, pkt1;

    function automatic mspf_pkg::shape_t shape(
        input logic signed [15:0] raw,
        input logic [14:0]        db
    );
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] db_s;
        logic [VW-1:0]        mag;
        logic [VW+6:0]        prod;
        mspf_pkg::shape_t     r;
        v = {{(VW-16){raw[15]}}, raw};
        if (v > ONE_Q)
        begin
            v = ONE_Q;
        end
        else if (v < -ONE_Q)
        begin
            v = -ONE_Q;
        end
        db_s    = {{(VW-15){1'b0}}, db};
        r.above = (v > db_s);
        r.below = (v < -db_s);
        mag     = v[VW-1] ? -v : v;
        // 127 * |v| as a shift and a subtract.
        prod    = {mag, 7'd0} - {7'd0, mag};
        r.value = (r.above || r.below) ? prod[FRAC_BITS+6:FRAC_BITS] : 7'd0;
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_addr_reg <= mspf_pkg::RST_PROPULSION_ADDR;
            conv_addr_reg <= mspf_pkg::RST_CONVEYOR_ADDR;
            deadband_reg  <= mspf_pkg::RST_DEADBAND;
            timeout_reg   <= mspf_pkg::RST_TIMEOUT_VALUE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mspf_pkg::REG_PROPULSION_ADDR: prop_addr_reg <= cfg_data[7:0];
                mspf_pkg::REG_CONVEYOR_ADDR:   conv_addr_reg <= cfg_data[7:0];
                mspf_pkg::REG_DEADBAND:        deadband_reg  <= cfg_data;
                mspf_pkg::REG_TIMEOUT_VALUE:   timeout_reg   <= cfg_data[6:0];
                default:                       timeout_reg   <= timeout_reg;
            endcase
        end
    end

    // Packet formation for an incoming item.
    always_comb
    begin
        speed_s    = shape(linear_speed, deadband_reg);
        turn_s     = shape(turn_rate, deadband_reg);
        drive_addr = (target == mspf_pkg::TARGET_PROPULSION) ? prop_addr_reg : conv_addr_reg;
        if (cmd == mspf_pkg::ITEM_TIMEOUT)
        begin
            pkt0 = mspf_pkg::make_packet(prop_addr_reg, mspf_pkg::OP_TIMEOUT,
                                         {1'b0, timeout_reg});
            pkt1 = mspf_pkg::make_packet(conv_addr_reg, mspf_pkg::OP_TIMEOUT,
                                         {1'b0, timeout_reg});
        end
        else
        begin
            pkt0 = mspf_pkg::make_packet(drive_addr,
                speed_s.above ? mspf_pkg::OP_FORWARD : mspf_pkg::OP_REVERSE,
                {1'b0, speed_s.value});
            pkt1 = mspf_pkg::make_packet(drive_addr,
                turn_s.above ? mspf_pkg::OP_LEFT : mspf_pkg::OP_RIGHT,
                {1'b0, turn_s.value});
        end
    end

    // Handshake and stage control.
    assign in_stall = a_valid_reg;
    assign in_fire  = in_valid && !a_valid_reg;
    assign out_fire = b_valid_reg && !out_stall;
    assign b_done   = out_fire && (b_cnt_reg == mspf_pkg::SLOT_LAST);
    assign b_load   = a_valid_reg && (!b_valid_reg || b_done);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        b_cnt_next   = b_cnt_reg;
        if (in_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_load)
        begin
            a_valid_next = 1'b0;
        end
        if (b_load)
        begin
            b_valid_next = 1'b1;
            b_cnt_next   = 3'd0;
        end
        else if (b_done)
        begin
            b_valid_next = 1'b0;
            b_cnt_next   = 3'd0;
        end
        else if (out_fire)
        begin
            b_cnt_next = b_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_cnt_reg   <= 3'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_cnt_reg   <= b_cnt_next;
        end
    end

    // Payload registers; the byte stage shifts toward byte 0 as bytes leave.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_bytes_reg <= {pkt1, pkt0};
        end
        if (b_load)
        begin
            b_bytes_reg <= a_bytes_reg;
        end
        else if (out_fire)
        begin
            b_bytes_reg <= {8'h00, b_bytes_reg[7:1]};
        end
    end

    assign out_valid = b_valid_reg;
    assign data_byte = b_bytes_reg[0];
    assign last      = (b_cnt_reg == mspf_pkg::SLOT_LAST);

`ifndef SYNTH
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> a_valid_reg)
        else $error("accepted item not held in the item stage");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last) |=> out_valid)
        else $error("byte stage dropped valid inside an item");

    a_check_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (b_cnt_reg == mspf_pkg::SLOT_FIRST_CHECK
                       || b_cnt_reg == mspf_pkg::SLOT_LAST)) |-> !data_byte[7])
        else $error("checksum byte has bit 7 set");

    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_valid_reg) |=> b_valid_reg)
        else $error("item stage waited behind an empty byte stage");
`endif

endmodule

FILE: dv/tb_motor_serial_packet_framer.sv
// ----------------------------------------------------------------------------
// tb_motor_serial_packet_framer
// Self-checking bench for the motor serial packet framer. Drive and timeout
// words go in through the valid/stall port, under several register settings
// and several patterns of sender gaps and receiver stalls. A predictor turns
// each accepted word into its eight serial bytes. Every byte that leaves the
// block is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_motor_serial_packet_framer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 14;
    localparam int RANDOM_WORDS = 56;
    localparam int PHASES       = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } serial_byte_t;

    // Predicts the serial bytes of each accepted word and checks the bytes
    // that come out against them, oldest first.
    class drive_packet_book;
        logic [7:0]   propulsion_addr;
        logic [7:0]   conveyor_addr;
        logic [14:0]  deadband;
        logic [6:0]   timeout_byte;
        serial_byte_t expected_bytes[$];
        int           errors;
        int           bytes_seen;
        int           drive_words;
        int           timeout_words;

        function new();
            propulsion_addr = mspf_pkg::RST_PROPULSION_ADDR;
            conveyor_addr   = mspf_pkg::RST_CONVEYOR_ADDR;
            deadband        = mspf_pkg::RST_DEADBAND;
            timeout_byte    = mspf_pkg::RST_TIMEOUT_VALUE;
        endfunction

        function void set_reg(logic [1:0] index, logic [14:0] value);
            case (index)
                mspf_pkg::REG_PROPULSION_ADDR: propulsion_addr = value[7:0];
                mspf_pkg::REG_CONVEYOR_ADDR:   conveyor_addr   = value[7:0];
                mspf_pkg::REG_DEADBAND:        deadband        = value;
                mspf_pkg::REG_TIMEOUT_VALUE:   timeout_byte    = value[6:0];
                default: ;
            endcase
        endfunction

        // Clamp to plus or minus 1.0, then apply the deadband with a strict test.
        function void shape_value(input logic signed [15:0] raw, output logic above,
                                  output logic [7:0] magnitude);
            int v;
            int one;
            int db;
            v         = raw;
            one       = 1 << FRAC_BITS;
            db        = int'(deadband);
            above     = 1'b0;
            magnitude = 8'd0;
            if (v > one)
                v = one;
            else if (v < -one)
                v = -one;
            if (v > db)
            begin
                above     = 1'b1;
                magnitude = 8'((127 * v) >>> FRAC_BITS);
            end
            else if (v < -db)
                magnitude = 8'((127 * -v) >>> FRAC_BITS);
        endfunction

        function void push_packet(logic [7:0] addr, logic [7:0] op, logic [7:0] val,
                                  logic closing);
            logic [7:0] sum;
            sum = addr + op + val;
            expected_bytes.push_back('{addr, 1'b0});
            expected_bytes.push_back('{op, 1'b0});
            expected_bytes.push_back('{val, 1'b0});
            expected_bytes.push_back('{sum & mspf_pkg::CHECK_MASK, closing});
        endfunction

        function void note_word(logic kind, logic target, logic signed [15:0] speed,
                                logic signed [15:0] turn);
            logic [7:0] addr;
            logic [7:0] magnitude;
            logic       above;
            if (kind == mspf_pkg::ITEM_TIMEOUT)
            begin
                timeout_words++;
                push_packet(propulsion_addr, mspf_pkg::OP_TIMEOUT,
                            {1'b0, timeout_byte}, 1'b0);
                push_packet(conveyor_addr, mspf_pkg::OP_TIMEOUT,
                            {1'b0, timeout_byte}, 1'b1);
            end
            else
            begin
                drive_words++;
                addr = (target == mspf_pkg::TARGET_PROPULSION) ? propulsion_addr
                                                               : conveyor_addr;
                shape_value(speed, above, magnitude);
                push_packet(addr, above ? mspf_pkg::OP_FORWARD : mspf_pkg::OP_REVERSE,
                            magnitude, 1'b0);
                shape_value(turn, above, magnitude);
                push_packet(addr, above ? mspf_pkg::OP_LEFT : mspf_pkg::OP_RIGHT,
                            magnitude, 1'b1);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            serial_byte_t want;
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                $error("byte 0x%02h with last=%0b arrived with nothing expected", data, last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = mspf_pkg::REG_PROPULSION_ADDR;
    logic [14:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        cmd          = mspf_pkg::ITEM_DRIVE;
    logic        target       = mspf_pkg::TARGET_PROPULSION;
    logic signed [15:0] linear_speed = '0;
    logic signed [15:0] turn_rate    = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  data_byte;
    logic        last;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int settings_used = 1;

    drive_packet_book board = new();

    motor_serial_packet_framer #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .target       (target),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_byte(data_byte, last);

    // All tasks start and end at a falling edge.
    task automatic send_word(logic kind, logic tgt, logic signed [15:0] speed,
                             logic signed [15:0] turn);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= kind;
        target       <= tgt;
        linear_speed <= speed;
        turn_rate    <= turn;
        do
            @(posedge clk);
        while (in_stall);
        board.note_word(kind, tgt, speed, turn);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(logic [7:0] prop, logic [7:0] conv, logic [14:0] db,
                                  logic [6:0] tmo);
        logic [14:0] values[4];
        values = '{{7'd0, prop}, {7'd0, conv}, db, {8'd0, tmo}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= values[i];
            board.set_reg(2'(i), values[i]);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Random Q2.14 value, weighted toward the deadband edges, zero and the clamp.
    function automatic logic signed [15:0] pick_rate();
        int db;
        db = int'(board.deadband);
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2: return 16'(($urandom_range(0, 1) ? db : -db) + int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 16)) - 8);
            4: return 16'(int'($urandom_range(0, 3)) - 1 + ($urandom_range(0, 1) ? 16384 : -16384));
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial
    begin
        int dir_rate[14] = '{0, 1, -1, 164, 165, -164, -165, 16384, -16384, 16385,
                             -16385, 32767, -32768, 16383};
        logic kind;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: extremes of both rates and the deadband edges.
        for (int i = 0; i < 14; i++)
            send_word(mspf_pkg::ITEM_DRIVE,
                      i[0] ? ~mspf_pkg::TARGET_PROPULSION : mspf_pkg::TARGET_PROPULSION,
                      16'(dir_rate[i]), 16'(dir_rate[13 - i]));
        send_word(mspf_pkg::ITEM_DRIVE, mspf_pkg::TARGET_PROPULSION, 16'sd165, -16'sd165);
        send_word(mspf_pkg::ITEM_DRIVE, ~mspf_pkg::TARGET_PROPULSION, -16'sd165, 16'sd165);
        send_word(mspf_pkg::ITEM_DRIVE, mspf_pkg::TARGET_PROPULSION, 16'sd164, -16'sd164);
        send_word(mspf_pkg::ITEM_DRIVE, ~mspf_pkg::TARGET_PROPULSION, 16'sh7FFF, 16'sh8000);
        send_word(mspf_pkg::ITEM_TIMEOUT, mspf_pkg::TARGET_PROPULSION, 16'h7FFF, 16'h8000);
        send_word(mspf_pkg::ITEM_TIMEOUT, ~mspf_pkg::TARGET_PROPULSION, 16'h8000, 16'h7FFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                case (phase)
                    1: apply_settings(8'd0, 8'd255, 15'd0, 7'd0);
                    2: apply_settings(8'd255, 8'd0, 15'd16384, 7'd127);
                    3: apply_settings(8'($urandom), 8'($urandom), 15'd16383, 7'($urandom));
                    4: apply_settings(8'($urandom), 8'($urandom),
                                      15'($urandom_range(0, 2000)), 7'($urandom));
                    5: apply_settings(8'($urandom), 8'($urandom),
                                      15'($urandom_range(0, 16384)), 7'($urandom));
                    6: apply_settings(mspf_pkg::RST_PROPULSION_ADDR,
                                      mspf_pkg::RST_CONVEYOR_ADDR,
                                      mspf_pkg::RST_DEADBAND,
                                      mspf_pkg::RST_TIMEOUT_VALUE);
                    default: apply_settings(8'($urandom), 8'($urandom), 15'd1, 7'd1);
                endcase
            end
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                // Let the output drain completely once in the middle of a phase.
                if (phase == 4 && n == RANDOM_WORDS / 2)
                    wait_idle();
                kind = ($urandom_range(0, 5) == 0) ? mspf_pkg::ITEM_TIMEOUT
                                                   : mspf_pkg::ITEM_DRIVE;
                send_word(kind, 1'($urandom), pick_rate(), pick_rate());
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d predicted bytes never arrived", board.pending());
            board.errors++;
        end
        $display("Sent %0d drive and %0d timeout words under %0d register settings,",
                 board.drive_words, board.timeout_words, settings_used);
        $display("checked %0d serial bytes with %0d mismatches.",
                 board.bytes_seen, board.errors);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run did not finish in time, %0d bytes still expected.", board.pending());
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mspf_pkg.sv
hw/rtl/motor_serial_packet_framer.sv
dv/tb_motor_serial_packet_framer.sv
